[src/dq_pkg.sv]
// Shared types, codes and ring arithmetic for the double-ended queue.
package dq_pkg;

    localparam int DEPTH  = 16;
    localparam int DATA_W = 32;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SUM_W  = IDX_W + 1;
    localparam int ACT_W  = 3;
    localparam int STAT_W = 2;

    // Request action codes; the eighth code is ignored
    localparam logic [ACT_W-1:0] ACT_PUSH_FRONT = 3'd0;
    localparam logic [ACT_W-1:0] ACT_PUSH_BACK  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_POP_FRONT  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_POP_BACK   = 3'd3;
    localparam logic [ACT_W-1:0] ACT_PEEK_FRONT = 3'd4;
    localparam logic [ACT_W-1:0] ACT_PEEK_BACK  = 3'd5;
    localparam logic [ACT_W-1:0] ACT_CLEAR      = 3'd6;

    // Response status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [ACT_W-1:0]         action;
        logic signed [DATA_W-1:0] push_value;
    } req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] read_value;
        logic [CNT_W-1:0]         entry_count;
        logic [STAT_W-1:0]        status;
    } rsp_t;

    // Add an offset below DEPTH to a ring index, wrapping once
    function automatic logic [IDX_W-1:0] ring_add(
        input logic [IDX_W-1:0] base,
        input logic [IDX_W-1:0] offset
    );
        logic [SUM_W-1:0] sum;
        sum = {1'b0, base} + {1'b0, offset};
        if (sum >= SUM_W'(DEPTH))
        begin
            sum = sum - SUM_W'(DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

endpackage

[src/dq_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module dq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write one word, read one word into the registered read data
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[src/double_ended_queue_top.sv]
// An accepted request passes the memory's registered read port, then the output register.
// Throughput: one request per cycle unless the response side stalls; the ring memory is
//   written or read at most once per request, and pointers are updated at acceptance,
//   so back-to-back requests need no interlock.
// Reset: front index, count and all valid flags clear; the ring contents stay undefined.
module double_ended_queue_top (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         req_valid,
    output logic         req_ready,
    input  dq_pkg::req_t req,
    output logic         rsp_valid,
    input  logic         rsp_ready,
    output dq_pkg::rsp_t rsp
);

    logic [dq_pkg::IDX_W-1:0]  front_reg;
    logic [dq_pkg::IDX_W-1:0]  front_next;
    logic [dq_pkg::CNT_W-1:0]  count_reg;
    logic [dq_pkg::CNT_W-1:0]  count_next;

    logic                      s1_valid_reg;
    logic                      s1_read_reg;
    logic [dq_pkg::CNT_W-1:0]  s1_count_reg;
    logic [dq_pkg::STAT_W-1:0] s1_status_reg;

    logic                      rsp_valid_reg;
    dq_pkg::rsp_t              rsp_reg;

    logic                      accept;
    logic                      rsp_free;
    logic                      s1_advance;

    logic                      wr_en;
    logic [dq_pkg::IDX_W-1:0]  wr_addr;
    logic                      rd_en;
    logic [dq_pkg::IDX_W-1:0]  rd_addr;
    logic [dq_pkg::DATA_W-1:0] rd_data;
    logic [dq_pkg::STAT_W-1:0] status_next;
    logic                      is_full;
    logic                      is_empty;
    logic [dq_pkg::IDX_W-1:0]  back_addr;
    logic [dq_pkg::IDX_W-1:0]  tail_addr;

    // Handshake: the output register frees when empty or when taken
    assign rsp_free   = !rsp_valid_reg || rsp_ready;
    assign s1_advance = s1_valid_reg && rsp_free;
    assign req_ready  = !s1_valid_reg || rsp_free;
    assign accept     = req_valid && req_ready;

    assign is_full  = (count_reg == dq_pkg::CNT_W'(dq_pkg::DEPTH));
    assign is_empty = (count_reg == '0);

    // Back entry for reads, first free slot for back pushes
    assign back_addr = dq_pkg::ring_add(front_reg, count_reg[dq_pkg::IDX_W-1:0] - 1'b1);
    assign tail_addr = dq_pkg::ring_add(front_reg, count_reg[dq_pkg::IDX_W-1:0]);

    // Decode the request: pointer update and memory access
    always_comb
    begin
        front_next  = front_reg;
        count_next  = count_reg;
        status_next = dq_pkg::ST_OK;
        wr_en       = 1'b0;
        wr_addr     = tail_addr;
        rd_en       = 1'b0;
        rd_addr     = front_reg;
        case (req.action)
            dq_pkg::ACT_PUSH_FRONT:
            begin
                if (is_full)
                begin
                    status_next = dq_pkg::ST_FULL;
                end
                else
                begin
                    front_next = dq_pkg::ring_add(front_reg,
                                                  dq_pkg::IDX_W'(dq_pkg::DEPTH - 1));
                    wr_en      = 1'b1;
                    wr_addr    = front_next;
                    count_next = count_reg + 1'b1;
                end
            end
            dq_pkg::ACT_PUSH_BACK:
            begin
                if (is_full)
                begin
                    status_next = dq_pkg::ST_FULL;
                end
                else
                begin
                    wr_en      = 1'b1;
                    wr_addr    = tail_addr;
                    count_next = count_reg + 1'b1;
                end
            end
            dq_pkg::ACT_POP_FRONT, dq_pkg::ACT_PEEK_FRONT:
            begin
                if (is_empty)
                begin
                    status_next = dq_pkg::ST_EMPTY;
                end
                else
                begin
                    rd_en   = 1'b1;
                    rd_addr = front_reg;
                    if (req.action == dq_pkg::ACT_POP_FRONT)
                    begin
                        front_next = dq_pkg::ring_add(front_reg, dq_pkg::IDX_W'(1));
                        count_next = count_reg - 1'b1;
                    end
                end
            end
            dq_pkg::ACT_POP_BACK, dq_pkg::ACT_PEEK_BACK:
            begin
                if (is_empty)
                begin
                    status_next = dq_pkg::ST_EMPTY;
                end
                else
                begin
                    rd_en   = 1'b1;
                    rd_addr = back_addr;
                    if (req.action == dq_pkg::ACT_POP_BACK)
                    begin
                        count_next = count_reg - 1'b1;
                    end
                end
            end
            dq_pkg::ACT_CLEAR:
            begin
                front_next = '0;
                count_next = '0;
            end
            default:
            begin
                // Unused code: leave everything as it is
            end
        endcase
    end

    // Ring store
    dq_ram #(
        .WIDTH (dq_pkg::DATA_W),
        .DEPTH (dq_pkg::DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (accept && wr_en),
        .wr_addr (wr_addr),
        .wr_data (req.push_value),
        .rd_en   (accept && rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Pointer and count registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            count_reg <= '0;
        end
        else if (accept)
        begin
            front_reg <= front_next;
            count_reg <= count_next;
        end
    end

    // Memory read stage: valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    // Memory read stage: hold the word's side information
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_read_reg   <= rd_en;
            s1_count_reg  <= count_next;
            s1_status_reg <= status_next;
        end
    end

    // Output register: valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (s1_advance)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    // Output register: load the response word
    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            rsp_reg.read_value  <= s1_read_reg ? rd_data : '0;
            rsp_reg.entry_count <= s1_count_reg;
            rsp_reg.status      <= s1_status_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

[src/dq_checker.sv]
// Port-level checks on the double-ended queue, bound to its top level.
module dq_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         req_valid,
    input logic         req_ready,
    input dq_pkg::req_t req,
    input logic         rsp_valid,
    input logic         rsp_ready,
    input dq_pkg::rsp_t rsp
);

    // Hold a stalled request word
    a_req_hold: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_ready |=> req_valid && $stable(req))
        else $error("request word changed while stalled");

    // Hold a stalled response word
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("response word changed while stalled");

    // Never report more entries than the ring holds
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.entry_count <= dq_pkg::CNT_W'(dq_pkg::DEPTH))
        else $error("entry count beyond depth");

    // A full report leaves the queue full
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == dq_pkg::ST_FULL
        |-> rsp.entry_count == dq_pkg::CNT_W'(dq_pkg::DEPTH) && rsp.read_value == '0)
        else $error("full status with queue not full");

    // An empty report leaves the queue empty and reads nothing
    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == dq_pkg::ST_EMPTY
        |-> rsp.entry_count == '0 && rsp.read_value == '0)
        else $error("empty status with queue not empty");

endmodule

bind double_ended_queue_top dq_checker u_dq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

[tb/testbench.sv]
// Self-checking testbench for the double-ended queue: directed corner cases, then random traffic.
module testbench;

    import dq_pkg::*;

    // The eighth action code has no meaning and must leave the queue untouched
    localparam logic [ACT_W-1:0] ACT_IGNORED = 3'd7;
    localparam int RANDOM_WORDS = 700;
    localparam int IDLE_LIMIT   = 2000;
    localparam int MAX_REPORTS  = 40;
    localparam int DRAIN_CYCLES = 8;

    typedef enum int {PH_FILL, PH_DRAIN, PH_MIXED, PH_NOISE} traffic_t;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    req_t req;
    logic rsp_valid;
    logic rsp_ready;
    rsp_t rsp;

    // Mirror of the queue contents and pointers
    logic signed [DATA_W-1:0] ring_mirror [DEPTH];
    logic [IDX_W-1:0]         head_idx   = '0;
    logic [CNT_W-1:0]         held_count = '0;

    rsp_t due_responses [$];
    int   error_count  = 0;
    int   idle_cycles  = 0;
    bit   sender_burst = 1'b0;

    double_ended_queue_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Wrap a ring position
    function automatic logic [IDX_W-1:0] ring_slot(input int base, input int offset);
        return IDX_W'((base + offset) % DEPTH);
    endfunction

    // Apply one request to the mirror and return the response it must give
    function automatic rsp_t predict_deque_response(input req_t word);
        rsp_t             result;
        logic [IDX_W-1:0] slot;
        result.read_value = '0;
        result.status     = ST_OK;
        case (word.action)
            ACT_PUSH_FRONT, ACT_PUSH_BACK:
            begin
                if (held_count >= CNT_W'(DEPTH))
                begin
                    result.status = ST_FULL;
                end
                else if (word.action == ACT_PUSH_FRONT)
                begin
                    head_idx              = ring_slot(head_idx, DEPTH - 1);
                    ring_mirror[head_idx] = word.push_value;
                    held_count++;
                end
                else
                begin
                    ring_mirror[ring_slot(head_idx, held_count)] = word.push_value;
                    held_count++;
                end
            end
            ACT_POP_FRONT, ACT_POP_BACK, ACT_PEEK_FRONT, ACT_PEEK_BACK:
            begin
                if (held_count == '0)
                begin
                    result.status = ST_EMPTY;
                end
                else
                begin
                    if (word.action == ACT_POP_FRONT || word.action == ACT_PEEK_FRONT)
                    begin
                        slot = head_idx;
                    end
                    else
                    begin
                        slot = ring_slot(head_idx, held_count - 1);
                    end
                    result.read_value = ring_mirror[slot];
                    if (word.action == ACT_POP_FRONT)
                    begin
                        head_idx = ring_slot(head_idx, 1);
                        held_count--;
                    end
                    else if (word.action == ACT_POP_BACK)
                    begin
                        held_count--;
                    end
                end
            end
            ACT_CLEAR:
            begin
                head_idx   = '0;
                held_count = '0;
            end
            default:
            begin
            end
        endcase
        result.entry_count = held_count;
        return result;
    endfunction

    task automatic report_mismatch(input string field, input longint got, input longint want);
        if (error_count < MAX_REPORTS)
        begin
            $display("%0t: %s mismatch: got %0d, expected %0d", $time, field, got, want);
        end
        error_count++;
    endtask

    // Predict on each accepted request, check each accepted response word
    always @(posedge clk)
    begin : check_words
        rsp_t want;
        if (rst_n)
        begin
            if (req_valid && req_ready)
            begin
                due_responses.push_back(predict_deque_response(req));
            end
            if (rsp_valid && rsp_ready)
            begin
                if (due_responses.size() == 0)
                begin
                    report_mismatch("unexpected response, entry_count", rsp.entry_count, -1);
                end
                else
                begin
                    want = due_responses.pop_front();
                    if (rsp.read_value !== want.read_value)
                        report_mismatch("read_value", rsp.read_value, want.read_value);
                    if (rsp.entry_count !== want.entry_count)
                        report_mismatch("entry_count", rsp.entry_count, want.entry_count);
                    if (rsp.status !== want.status)
                        report_mismatch("status", rsp.status, want.status);
                end
            end
        end
    end

    // Abort when neither channel moves a word for too long
    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("double_ended_queue_top regression: fail");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Stall the response side: ready stretches broken by random holds
    initial
    begin : stall_responses
        int run;
        int hold;
        rsp_ready = 1'b0;
        wait (rst_n);
        forever
        begin
            run       = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                    : $urandom_range(1, 8);
            rsp_ready = 1'b1;
            repeat (run) @(negedge clk);
            hold = pick_gap();
            if (hold > 0)
            begin
                rsp_ready = 1'b0;
                repeat (hold) @(negedge clk);
            end
        end
    end

    // Offer one request word and hold it until accepted; entered and left at a falling edge
    task automatic send_request(input req_t word);
        int gap;
        gap = sender_burst ? 0 : pick_gap();
        if (gap > 0)
        begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req       = word;
        req_valid = 1'b1;
        do
            @(posedge clk);
        while (!req_ready);
        @(negedge clk);
    endtask

    // Drop valid and hold off until every expected response has been taken
    task automatic wait_for_drain();
        req_valid = 1'b0;
        while (due_responses.size() != 0)
            @(negedge clk);
    endtask

    function automatic req_t make_request(input logic [ACT_W-1:0] action,
                                          input logic signed [DATA_W-1:0] value);
        req_t word;
        word.action     = action;
        word.push_value = value;
        return word;
    endfunction

    function automatic logic signed [DATA_W-1:0] random_value();
        case ($urandom_range(0, 9))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return '0;
            3:       return -1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [ACT_W-1:0] pick_push();
        return $urandom_range(0, 1) ? ACT_PUSH_FRONT : ACT_PUSH_BACK;
    endfunction

    function automatic logic [ACT_W-1:0] pick_read();
        case ($urandom_range(0, 3))
            0:       return ACT_POP_FRONT;
            1:       return ACT_POP_BACK;
            2:       return ACT_PEEK_FRONT;
            default: return ACT_PEEK_BACK;
        endcase
    endfunction

    // Build a random word whose action mix depends on the traffic kind
    function automatic req_t random_request(input traffic_t kind);
        int               roll;
        logic [ACT_W-1:0] action;
        roll = $urandom_range(0, 99);
        case (kind)
            PH_FILL:  action = (roll < 80) ? pick_push() : pick_read();
            PH_DRAIN: action = (roll < 80) ? pick_read() : pick_push();
            PH_MIXED: action = (roll < 48) ? pick_push() : (roll < 96) ? pick_read() : ACT_CLEAR;
            default:
            begin
                if (roll < 35)
                    action = pick_push();
                else if (roll < 70)
                    action = pick_read();
                else if (roll < 85)
                    action = ACT_CLEAR;
                else
                    action = ACT_IGNORED;
            end
        endcase
        return make_request(action, random_value());
    endfunction

    // Pops and peeks on the empty queue straight after reset
    task automatic test_empty_requests();
        send_request(make_request(ACT_POP_FRONT, random_value()));
        send_request(make_request(ACT_POP_BACK, random_value()));
        send_request(make_request(ACT_PEEK_FRONT, random_value()));
        send_request(make_request(ACT_PEEK_BACK, random_value()));
    endtask

    // Extreme values at both ends; the front push wraps the head below zero
    task automatic test_value_extremes();
        send_request(make_request(ACT_PUSH_FRONT, 32'sh7FFF_FFFF));
        send_request(make_request(ACT_PUSH_BACK, 32'sh8000_0000));
        send_request(make_request(ACT_PEEK_FRONT, '0));
        send_request(make_request(ACT_PEEK_BACK, -1));
        send_request(make_request(ACT_POP_BACK, 32'sh5555_5555));
        send_request(make_request(ACT_POP_FRONT, 32'shAAAA_AAAA));
        send_request(make_request(ACT_POP_FRONT, '0));
    endtask

    // The unused action code must change nothing
    task automatic test_ignored_code();
        send_request(make_request(ACT_PUSH_BACK, 1));
        send_request(make_request(ACT_IGNORED, -1));
        send_request(make_request(ACT_PEEK_BACK, '0));
        send_request(make_request(ACT_POP_FRONT, '0));
    endtask

    // Clear empties the queue and resets the head
    task automatic test_clear();
        send_request(make_request(ACT_PUSH_FRONT, 32'sh1234_5678));
        send_request(make_request(ACT_PUSH_BACK, -32'sd99));
        send_request(make_request(ACT_CLEAR, 32'sh0F0F_0F0F));
        send_request(make_request(ACT_PEEK_FRONT, '0));
        send_request(make_request(ACT_PUSH_BACK, 32'sd42));
        send_request(make_request(ACT_PEEK_FRONT, '0));
        send_request(make_request(ACT_POP_BACK, '0));
    endtask

    // Phases that fill, drain and mix, so full and empty are both reached often
    task automatic test_random_traffic();
        int       sent;
        int       phase_len;
        traffic_t kind;
        req_t     word;
        sent = 0;
        while (sent < RANDOM_WORDS)
        begin
            kind         = traffic_t'($urandom_range(0, 3));
            phase_len    = $urandom_range(8, 48);
            sender_burst = ($urandom_range(0, 4) == 0);
            repeat (phase_len)
            begin
                word = random_request(kind);
                send_request(word);
                if (word.action != ACT_IGNORED)
                    sent++;
            end
            if ($urandom_range(0, 5) == 0)
                wait_for_drain();
        end
        sender_burst = 1'b0;
    endtask

    initial
    begin
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        test_empty_requests();
        wait_for_drain();
        test_value_extremes();
        wait_for_drain();
        test_ignored_code();
        test_clear();
        wait_for_drain();
        test_random_traffic();
        wait_for_drain();

        // Let any stray response word surface before judging
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && due_responses.size() == 0)
            $display("double_ended_queue_top regression: pass");
        else
            $display("double_ended_queue_top regression: fail");
        $finish;
    end

endmodule
